// File: rtl/core/bsre_pkg.sv
// bsre_pkg: types, constants and codes shared by the bit-plane scanline encoder
// used by bsre_ctrl, bsre_dp and bitplane_scanline_rle_encoder
package bsre_pkg;

  // geometry limits
  localparam int MAX_LINE_BYTES = 256;
  localparam int MAX_PLANES     = 8;
  localparam int STORE_DEPTH    = MAX_LINE_BYTES * MAX_PLANES;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int FILL_W         = STORE_AW + 1;
  localparam int LB_W           = 9;
  localparam int PC_W           = 4;
  localparam int LC_W           = 16;
  localparam int XW             = $clog2(MAX_LINE_BYTES + 1);

  // plane-line code buffer
  localparam int CODE_DEPTH = 512;
  localparam int CODE_AW    = $clog2(CODE_DEPTH);
  localparam int POS_W      = 11;

  // token limits
  localparam int SOLID_MAX = 127;
  localparam int RUN_MAX   = 255;
  localparam int RAW_CHUNK = 255;
  localparam int REPEAT_MAX = 255;

  // coded byte values
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_LIT  = 8'h80;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_LINE_BYTES  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PLANE_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LINE_COUNT  = 2'd2;

  // item commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PUSH = 3'b010,
    ST_PULL = 3'b100
  } ctrl_state_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HEAD  = 4'b0010,
    PH_PLANE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [5:0] {
    EM_NONE = 6'b000001,
    EM_ZERO = 6'b000010,
    EM_ONES = 6'b000100,
    EM_PAT  = 6'b001000,
    EM_PWR  = 6'b010000,
    EM_LIT  = 6'b100000
  } enc_mode_t;

  typedef enum logic [2:0] {
    RS_HDR  = 3'b001,
    RS_LEN  = 3'b010,
    RS_DATA = 3'b100
  } raw_sub_t;

  // controller to datapath
  typedef struct packed {
    logic       push_rd;
    logic       push_wr;
    logic       head_pull;
    logic       pull_rd;
    logic       pull_wr;
    logic [7:0] data;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       busy;
    logic       push_ok;
    logic       ph_head;
    logic       ph_plane;
    logic [7:0] head_byte;
    logic [7:0] pull_byte;
    logic       pull_last;
  } status_t;

endpackage

// File: rtl/core/bsre_ctrl.sv
// bsre_ctrl: item handshake, sequencing state machine and result register
// depends on bsre_pkg
module bsre_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bsre_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output bsre_pkg::result_t result,
  output bsre_pkg::cmd_t    cmd,
  input  bsre_pkg::status_t status
);
  import bsre_pkg::*;

  ctrl_state_t state, state_next;
  logic        slot_free;
  logic        take;
  logic        res_load;
  result_t     res_next;

  // one item in flight, result slot frees as it is taken
  assign slot_free  = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE) && !status.busy && slot_free;
  assign take       = item_valid && item_ready;

  // sequencing
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.data   = item.data_byte;
    res_load   = 1'b0;
    res_next   = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (item.command == CMD_PUSH) begin
            if (status.push_ok) begin
              cmd.push_rd = 1'b1;
              state_next  = ST_PUSH;
            end else begin
              res_load = 1'b1;
            end
          end else if (status.ph_head) begin
            cmd.head_pull      = 1'b1;
            res_load           = 1'b1;
            res_next.out_valid = 1'b1;
            res_next.out_byte  = status.head_byte;
          end else if (status.ph_plane) begin
            cmd.pull_rd = 1'b1;
            state_next  = ST_PULL;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_PUSH: begin
        cmd.push_wr       = 1'b1;
        res_load          = 1'b1;
        res_next.accepted = 1'b1;
        state_next        = ST_IDLE;
      end
      ST_PULL: begin
        cmd.pull_wr        = 1'b1;
        res_load           = 1'b1;
        res_next.out_valid = 1'b1;
        res_next.out_byte  = status.pull_byte;
        res_next.out_last  = status.pull_last;
        state_next         = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

endmodule

// File: rtl/core/bsre_dp.sv
// bsre_dp: row stores, group and emit counters, plane-line coder and code buffer
// depends on bsre_pkg
module bsre_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bsre_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bsre_pkg::CFG_DW-1:0] cfg_data,
  input  bsre_pkg::cmd_t              cmd,
  output bsre_pkg::status_t           status
);
  import bsre_pkg::*;

  // configuration and geometry
  logic [LB_W-1:0]   line_bytes;
  logic [PC_W-1:0]   plane_count;
  logic [LC_W-1:0]   line_count;
  logic [LB_W-1:0]   geo_w;
  logic [PC_W-1:0]   geo_p;
  logic [LC_W-1:0]   geo_rows;
  logic [LB_W+PC_W-1:0] row_prod;
  logic [FILL_W-1:0] row_len;

  // stores
  logic [7:0] bank0 [STORE_DEPTH];
  logic [7:0] bank1 [STORE_DEPTH];
  logic [7:0] code_mem [CODE_DEPTH];
  logic [7:0] bank0_rd, bank1_rd, held_rd, code_rd;
  logic [STORE_AW-1:0] held_addr;

  // stream state
  logic              sel, sel_next;
  logic [7:0]        pbyte;
  logic              match, match_next;
  logic [7:0]        repeat_cnt, repeat_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [LC_W-1:0]   rows_rcvd, rows_next;
  logic [PC_W-1:0]   plane, plane_next;
  logic [STORE_AW-1:0] base, base_next;
  logic [POS_W-1:0]  epos, epos_next;
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  clen, clen_next;
  logic [2:0]        tok, tok_next;
  logic              rawf, rawf_next;
  raw_sub_t          rsub, rsub_next;
  logic [XW-1:0]     raw_left, raw_left_next;
  logic [7:0]        run_left, run_left_next;
  logic [XW-1:0]     rx, rx_next;

  // coder state
  logic              enc_run, enc_run_next;
  logic [XW-1:0]     fidx, fidx_next;
  logic              pend, pend_next;
  logic [7:0]        win0, win1, win2, win0_next, win1_next, win2_next;
  logic [1:0]        wcnt, wcnt_next;
  enc_mode_t         mode, mode_next;
  logic [7:0]        cnt, cnt_next;
  logic [7:0]        pat_v, pat_v_next;
  logic [POS_W-1:0]  n, n_next;
  logic [POS_W-1:0]  hdr, hdr_next;
  logic [1:0]        pw, pw_next;

  // helpers
  logic              enc_ready, three_eq, consume, issue;
  logic              cw_en;
  logic [POS_W-1:0]  cw_addr;
  logic [7:0]        cw_data;
  logic [POS_W-1:0]  limit, raw_len;
  logic              mism, match_t;
  logic [FILL_W-1:0] fill_inc;
  logic [LC_W-1:0]   rows_inc;
  logic [PC_W-1:0]   plane_inc;
  logic              plane_end;
  logic [7:0]        run_len;
  logic [2:0]        tok_inc;
  logic              start_grp, build_req, group_end;

  // geometry clamps
  always_comb begin
    if (line_bytes == '0) begin
      geo_w = LB_W'(1);
    end else if (line_bytes > LB_W'(MAX_LINE_BYTES)) begin
      geo_w = LB_W'(MAX_LINE_BYTES);
    end else begin
      geo_w = line_bytes;
    end
    if (plane_count == '0) begin
      geo_p = PC_W'(1);
    end else if (plane_count > PC_W'(MAX_PLANES)) begin
      geo_p = PC_W'(MAX_PLANES);
    end else begin
      geo_p = plane_count;
    end
    geo_rows = (line_count == '0) ? LC_W'(1) : line_count;
  end

  assign row_prod = (LB_W+PC_W)'(geo_w) * (LB_W+PC_W)'(geo_p);
  assign row_len  = row_prod[FILL_W-1:0];

  // length bound of a coded plane line and of its raw form
  assign limit   = POS_W'(geo_w) + ((geo_w >= LB_W'(RAW_CHUNK)) ? POS_W'(4) : POS_W'(2));
  assign raw_len = POS_W'(geo_w) + ((geo_w > LB_W'(RAW_CHUNK)) ? POS_W'(4) : POS_W'(2));

  // held row read address: coder fetch, push compare or raw emission
  always_comb begin
    if (enc_run) begin
      held_addr = base + STORE_AW'(fidx);
    end else if (cmd.push_rd) begin
      held_addr = fill[STORE_AW-1:0];
    end else begin
      held_addr = base + STORE_AW'(rx);
    end
  end

  // row banks, incoming is the bank not held
  always_ff @(posedge clk) begin
    if (cmd.push_wr && sel) begin
      bank0[fill[STORE_AW-1:0]] <= pbyte;
    end
    if (cmd.push_wr && !sel) begin
      bank1[fill[STORE_AW-1:0]] <= pbyte;
    end
    bank0_rd <= bank0[held_addr];
    bank1_rd <= bank1[held_addr];
  end

  assign held_rd = sel ? bank1_rd : bank0_rd;

  // plane-line code buffer
  always_ff @(posedge clk) begin
    if (cw_en && (cw_addr < POS_W'(CODE_DEPTH))) begin
      code_mem[cw_addr[CODE_AW-1:0]] <= cw_data;
    end
    code_rd <= code_mem[epos[CODE_AW-1:0]];
  end

  // byte latch for a push
  always_ff @(posedge clk) begin
    if (cmd.push_rd) begin
      pbyte <= cmd.data;
    end
  end

  // coder window status
  assign enc_ready = !pend && ((wcnt == 2'd3) || (fidx == geo_w));
  assign three_eq  = (wcnt == 2'd3) && (win1 == win0) && (win2 == win0);
  assign run_len   = (raw_left >= XW'(RAW_CHUNK)) ? 8'(RAW_CHUNK) : raw_left[7:0];
  assign tok_inc   = {1'b0, tok[1:0]} + 3'd1;
  assign plane_inc = plane + PC_W'(1);
  assign plane_end = (epos + POS_W'(1)) >= clen;
  assign group_end = plane_end && (plane_inc >= geo_p);
  assign mism      = (rows_rcvd != '0) && (held_rd != pbyte);
  assign match_t   = match && !mism;
  assign fill_inc  = fill + FILL_W'(1);
  assign rows_inc  = rows_rcvd + LC_W'(1);

  // next state
  always_comb begin
    sel_next      = sel;
    match_next    = match;
    repeat_next   = repeat_cnt;
    fill_next     = fill;
    rows_next     = rows_rcvd;
    plane_next    = plane;
    base_next     = base;
    epos_next     = epos;
    phase_next    = phase;
    clen_next     = clen;
    tok_next      = tok;
    rawf_next     = rawf;
    rsub_next     = rsub;
    raw_left_next = raw_left;
    run_left_next = run_left;
    rx_next       = rx;
    enc_run_next  = enc_run;
    fidx_next     = fidx;
    win0_next     = win0;
    win1_next     = win1;
    win2_next     = win2;
    wcnt_next     = wcnt;
    mode_next     = mode;
    cnt_next      = cnt;
    pat_v_next    = pat_v;
    n_next        = n;
    hdr_next      = hdr;
    pw_next       = pw;
    consume       = 1'b0;
    cw_en         = 1'b0;
    cw_addr       = n;
    cw_data       = BYTE_ZERO;
    start_grp     = 1'b0;
    build_req     = 1'b0;

    // plane-line coder, one token step per cycle unless waiting on the fetch window
    if (enc_run) begin
      case (mode)
        EM_PWR: begin
          cw_en   = 1'b1;
          cw_data = (pw == 2'd0) ? BYTE_ZERO : ((pw == 2'd1) ? cnt : pat_v);
          n_next  = n + POS_W'(1);
          pw_next = pw + 2'd1;
          if (pw == 2'd2) begin
            mode_next = EM_NONE;
          end
        end
        EM_NONE: begin
          if (enc_ready) begin
            if (wcnt == 2'd0) begin
              // end of the plane line: pick coded or raw form
              enc_run_next = 1'b0;
              rawf_next    = n > limit;
              clen_next    = (n > limit) ? raw_len : n;
              rsub_next    = RS_HDR;
              raw_left_next = XW'(geo_w);
              rx_next      = '0;
            end else if (win0 == BYTE_ZERO) begin
              mode_next = EM_ZERO;
              cnt_next  = 8'd1;
              consume   = 1'b1;
            end else if (win0 == BYTE_ONES) begin
              mode_next = EM_ONES;
              cnt_next  = 8'd1;
              consume   = 1'b1;
            end else if (three_eq) begin
              mode_next  = EM_PAT;
              pat_v_next = win0;
              cnt_next   = 8'd1;
              consume    = 1'b1;
            end else begin
              cw_en     = 1'b1;
              cw_data   = BYTE_LIT;
              hdr_next  = n + POS_W'(1);
              n_next    = n + POS_W'(2);
              mode_next = EM_LIT;
              cnt_next  = 8'd0;
            end
          end
        end
        EM_LIT: begin
          if (enc_ready) begin
            if ((wcnt != 2'd0) && (cnt < 8'(RUN_MAX)) &&
                ((cnt == 8'd0) || !three_eq)) begin
              cw_en    = 1'b1;
              cw_data  = win0;
              n_next   = n + POS_W'(1);
              cnt_next = cnt + 8'd1;
              consume  = 1'b1;
            end else begin
              cw_en     = 1'b1;
              cw_addr   = hdr;
              cw_data   = cnt;
              mode_next = EM_NONE;
            end
          end
        end
        EM_ZERO, EM_ONES: begin
          if (enc_ready) begin
            if ((wcnt != 2'd0) && (cnt < 8'(SOLID_MAX)) &&
                (win0 == ((mode == EM_ZERO) ? BYTE_ZERO : BYTE_ONES))) begin
              cnt_next = cnt + 8'd1;
              consume  = 1'b1;
            end else begin
              cw_en     = 1'b1;
              cw_data   = (mode == EM_ZERO) ? cnt : {1'b1, cnt[6:0]};
              n_next    = n + POS_W'(1);
              mode_next = EM_NONE;
            end
          end
        end
        EM_PAT: begin
          if (enc_ready) begin
            if ((wcnt != 2'd0) && (win0 == pat_v) && (cnt < 8'(RUN_MAX))) begin
              cnt_next = cnt + 8'd1;
              consume  = 1'b1;
            end else begin
              mode_next = EM_PWR;
              pw_next   = 2'd0;
            end
          end
        end
        default: mode_next = EM_NONE;
      endcase
    end

    // coder fetch window: issued reads reach the window via the bank read register
    if (consume) begin
      issue = enc_run && (fidx < geo_w);
    end else if (pend) begin
      issue = enc_run && (fidx < geo_w) && (wcnt < 2'd2);
    end else begin
      issue = enc_run && (fidx < geo_w) && (wcnt < 2'd3);
    end
    if (issue) begin
      fidx_next = fidx + XW'(1);
    end
    pend_next = issue;
    if (consume) begin
      win0_next = win1;
      win1_next = win2;
      wcnt_next = wcnt - 2'd1;
    end else if (pend) begin
      case (wcnt)
        2'd0:    win0_next = held_rd;
        2'd1:    win1_next = held_rd;
        default: win2_next = held_rd;
      endcase
      wcnt_next = wcnt + 2'd1;
    end

    // write step of an accepted push (ST_PUSH)
    if (cmd.push_wr) begin
      match_next = match_t;
      fill_next  = fill_inc;
      if (fill_inc == row_len) begin
        rows_next = rows_inc;
        if (rows_inc == LC_W'(1)) begin
          sel_next    = !sel;
          fill_next   = '0;
          repeat_next = 8'd1;
          match_next  = 1'b1;
          start_grp   = rows_inc >= geo_rows;
        end else if (match_t && (repeat_cnt < 8'(REPEAT_MAX))) begin
          repeat_next = repeat_cnt + 8'd1;
          fill_next   = '0;
          match_next  = 1'b1;
          start_grp   = rows_inc >= geo_rows;
        end else begin
          start_grp = 1'b1;
        end
      end
    end

    // group header byte
    if (cmd.head_pull) begin
      tok_next = tok_inc;
      if (tok_inc >= 3'd4) begin
        build_req = 1'b1;
      end
    end

    // write step of a plane byte pull (ST_PULL)
    if (cmd.pull_wr) begin
      epos_next = epos + POS_W'(1);
      case (rsub)
        RS_HDR: rsub_next = RS_LEN;
        RS_LEN: begin
          rsub_next     = RS_DATA;
          run_left_next = run_len;
        end
        RS_DATA: begin
          rx_next       = rx + XW'(1);
          raw_left_next = raw_left - XW'(1);
          run_left_next = run_left - 8'd1;
          if (run_left == 8'd1) begin
            rsub_next = RS_HDR;
          end
        end
        default: rsub_next = RS_HDR;
      endcase
      if (plane_end) begin
        plane_next = plane_inc;
        if (plane_inc >= geo_p) begin
          if (fill == row_len) begin
            sel_next    = !sel;
            fill_next   = '0;
            repeat_next = 8'd1;
            match_next  = 1'b1;
            if (rows_rcvd >= geo_rows) begin
              start_grp = 1'b1;
            end else begin
              phase_next = PH_IDLE;
            end
          end else if (rows_rcvd >= geo_rows) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          base_next = base + STORE_AW'(geo_w);
          build_req = 1'b1;
        end
      end
    end

    // group start: header first when rows repeat
    if (start_grp) begin
      plane_next = '0;
      base_next  = '0;
      if (repeat_next > 8'd1) begin
        tok_next   = '0;
        phase_next = PH_HEAD;
      end else begin
        build_req = 1'b1;
      end
    end

    // plane-line coder launch
    if (build_req) begin
      enc_run_next = 1'b1;
      fidx_next    = '0;
      pend_next    = 1'b0;
      wcnt_next    = '0;
      mode_next    = EM_NONE;
      n_next       = '0;
      epos_next    = '0;
      phase_next   = PH_PLANE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_index == CFG_LINE_BYTES || cfg_index == CFG_PLANE_COUNT ||
                           cfg_index == CFG_LINE_COUNT))) begin
      match      <= 1'b1;
      repeat_cnt <= 8'd1;
      fill       <= '0;
      rows_rcvd  <= '0;
      plane      <= '0;
      base       <= '0;
      epos       <= '0;
      phase      <= PH_IDLE;
      clen       <= '0;
      tok        <= '0;
      rawf       <= 1'b0;
      enc_run    <= 1'b0;
      pend       <= 1'b0;
      mode       <= EM_NONE;
      rsub       <= RS_HDR;
    end else begin
      match      <= match_next;
      repeat_cnt <= repeat_next;
      fill       <= fill_next;
      rows_rcvd  <= rows_next;
      plane      <= plane_next;
      base       <= base_next;
      epos       <= epos_next;
      phase      <= phase_next;
      clen       <= clen_next;
      tok        <= tok_next;
      rawf       <= rawf_next;
      enc_run    <= enc_run_next;
      pend       <= pend_next;
      mode       <= mode_next;
      rsub       <= rsub_next;
    end
  end

  // bank select and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sel         <= 1'b0;
      line_bytes  <= LB_W'(1);
      plane_count <= PC_W'(1);
      line_count  <= LC_W'(1);
    end else begin
      sel <= sel_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_BYTES:  line_bytes  <= cfg_data[LB_W-1:0];
          CFG_PLANE_COUNT: plane_count <= cfg_data[PC_W-1:0];
          CFG_LINE_COUNT:  line_count  <= cfg_data[LC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // coder and raw emission payload registers
  always_ff @(posedge clk) begin
    raw_left <= raw_left_next;
    run_left <= run_left_next;
    rx       <= rx_next;
    fidx     <= fidx_next;
    win0     <= win0_next;
    win1     <= win1_next;
    win2     <= win2_next;
    wcnt     <= wcnt_next;
    cnt      <= cnt_next;
    pat_v    <= pat_v_next;
    n        <= n_next;
    hdr      <= hdr_next;
    pw       <= pw_next;
  end

  // status to the controller
  always_comb begin
    status           = '0;
    status.busy      = enc_run;
    status.push_ok   = (phase == PH_IDLE) && (rows_rcvd < geo_rows) && (fill < row_len);
    status.ph_head   = phase == PH_HEAD;
    status.ph_plane  = phase == PH_PLANE;
    case (tok[1:0])
      2'd3:    status.head_byte = repeat_cnt;
      2'd2:    status.head_byte = BYTE_ONES;
      default: status.head_byte = BYTE_ZERO;
    endcase
    if (!rawf) begin
      status.pull_byte = code_rd;
    end else if (rsub == RS_HDR) begin
      status.pull_byte = BYTE_LIT;
    end else if (rsub == RS_LEN) begin
      status.pull_byte = run_len;
    end else begin
      status.pull_byte = held_rd;
    end
    status.pull_last = group_end && (fill != row_len) && (rows_rcvd >= geo_rows);
  end

endmodule

// File: rtl/core/bitplane_scanline_rle_encoder.sv
// bitplane_scanline_rle_encoder: top level, controller plus datapath
// depends on bsre_pkg, bsre_ctrl, bsre_dp
//
// Items arrive on item_valid/item_ready; command 0 pushes one image byte
// (rows in order, each row as its plane lines), command 1 pulls one coded
// byte. Each item gives exactly one result on result_valid/result_ready:
// accepted for a push, out_valid/out_byte/out_last for a pull.
// A refused push, a header pull or an empty pull is answered from ST_IDLE;
// an accepted push or a plane byte pull goes on to ST_PUSH or ST_PULL for
// the registered reads of the row banks and the code buffer. One item is
// handled at a time. Before a plane line's first byte the coder makes one
// pass over the line: it fills its fetch window, gathers bytes into zero,
// ones, pattern and literal tokens and writes each token to the code buffer;
// item_ready is low during that pass.
// Row bank swap replaces copying, so a new row needs no copy pass.
// Reset (or a configuration write to one of the three registers) restarts
// the image; no clearing pass. If the receiver stalls, the result is held
// and the next item is taken in the cycle the held result is taken.
module bitplane_scanline_rle_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  bsre_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output bsre_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [bsre_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bsre_pkg::CFG_DW-1:0] cfg_data
);
  import bsre_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing and handshakes
  bsre_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

  // stores, counters and coder
  bsre_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  // no item taken while the coder runs
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !item_ready)
    else $error("item taken during coder pass");

  // an accepted item is answered next cycle or blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (result_valid || !item_ready))
    else $error("second item taken while one is in flight");

  // a result is either a push answer or a pull answer
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.accepted && result.out_valid) &&
                     (!result.out_last || result.out_valid))
    else $error("inconsistent result fields");

endmodule

// File: tb/bitplane_scanline_rle_encoder_tb.sv
// bitplane_scanline_rle_encoder_tb: self-checking bench for the bit-plane scanline encoder
// depends on bsre_pkg and the bitplane_scanline_rle_encoder rtl; pushes image rows, pulls
// coded bytes and compares each result against an in-bench model of the coder
module bitplane_scanline_rle_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsre_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 1500;

  // expected-result store plus the encoder model that fills it
  class encoder_scoreboard;
    int unsigned lb_reg, pc_reg, lc_reg;
    logic [7:0] held[STORE_DEPTH];
    logic [7:0] incoming[STORE_DEPTH];
    logic [7:0] code[1024];
    bit rows_match;
    int unsigned repeats, fill, rows_in, cur_plane, emit_pos, code_len, head_idx;
    phase_t ph;
    result_t expected_q[$];
    int errors;

    function new();
      lb_reg = 1; pc_reg = 1; lc_reg = 1;
      errors = 0;
      restart();
    endfunction

    function int unsigned geo_w();
      if (lb_reg == 0) return 1;
      return (lb_reg > MAX_LINE_BYTES) ? MAX_LINE_BYTES : lb_reg;
    endfunction

    function int unsigned geo_p();
      if (pc_reg == 0) return 1;
      return (pc_reg > MAX_PLANES) ? MAX_PLANES : pc_reg;
    endfunction

    function int unsigned geo_rows();
      return (lc_reg == 0) ? 1 : lc_reg;
    endfunction

    function void restart();
      rows_match = 1; repeats = 1; fill = 0; rows_in = 0;
      cur_plane = 0; emit_pos = 0; ph = PH_IDLE; code_len = 0; head_idx = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_LINE_BYTES:  lb_reg = 32'(val & 16'h1ff);
        CFG_PLANE_COUNT: pc_reg = 32'(val & 16'h000f);
        CFG_LINE_COUNT:  lc_reg = 32'(val);
        default: return;
      endcase
      restart();
    endfunction

    // code one plane line of the held row, with raw fallback
    function void build_plane();
      int unsigned w, base, n, x, cnt, hdr, lim, left, run;
      logic [7:0] v;
      w = geo_w(); base = cur_plane * w; n = 0; x = 0;
      while (x < w) begin
        v = held[base + x]; cnt = 1; x++;
        if (v == BYTE_ZERO) begin
          while (x < w && held[base + x] == BYTE_ZERO && cnt < SOLID_MAX) begin x++; cnt++; end
          code[n++] = cnt[7:0];
        end else if (v == BYTE_ONES) begin
          while (x < w && held[base + x] == BYTE_ONES && cnt < SOLID_MAX) begin x++; cnt++; end
          code[n++] = BYTE_LIT | cnt[7:0];
        end else if (x + 1 < w && held[base + x] == v && held[base + x + 1] == v) begin
          while (x < w && held[base + x] == v && cnt < RUN_MAX) begin x++; cnt++; end
          code[n++] = BYTE_ZERO; code[n++] = cnt[7:0]; code[n++] = v;
        end else begin
          hdr = n;
          code[n++] = BYTE_LIT; n++; code[n++] = v;
          while (x < w && cnt < RUN_MAX) begin
            if (x + 3 > w || !(held[base + x] == held[base + x + 1] &&
                               held[base + x] == held[base + x + 2])) begin
              code[n++] = held[base + x]; x++; cnt++;
            end else break;
          end
          code[hdr + 1] = cnt[7:0];
        end
      end
      lim = 2 * (w / 255 + 1) + w;
      if (n > lim) begin
        n = 0; x = 0; left = w;
        while (left > 0) begin
          run = (left >= RAW_CHUNK) ? RAW_CHUNK : left;
          code[n++] = BYTE_LIT; code[n++] = run[7:0];
          for (int i = 0; i < run; i++) code[n++] = held[base + x + i];
          x += run; left -= run;
        end
      end
      code_len = n; emit_pos = 0; ph = PH_PLANE;
    endfunction

    function void start_group();
      cur_plane = 0;
      if (repeats > 1) begin
        head_idx = 0; ph = PH_HEAD;
      end else build_plane();
    endfunction

    function void take_incoming();
      for (int i = 0; i < geo_w() * geo_p(); i++) held[i] = incoming[i];
      fill = 0; repeats = 1; rows_match = 1;
    endfunction

    function bit finish_group();
      if (fill == geo_w() * geo_p()) begin
        take_incoming();
        if (rows_in >= geo_rows()) start_group();
        else ph = PH_IDLE;
        return 0;
      end
      if (rows_in >= geo_rows()) begin
        ph = PH_DONE; return 1;
      end
      ph = PH_IDLE;
      return 0;
    endfunction

    // note an accepted item, queue and return its expected result
    function result_t note_item(item_t it);
      result_t r;
      int unsigned row_len;
      r = '0;
      row_len = geo_w() * geo_p();
      if (it.command == CMD_PUSH) begin
        if (!(ph != PH_IDLE || rows_in >= geo_rows() || fill >= row_len)) begin
          r.accepted = 1;
          incoming[fill] = it.data_byte;
          if (rows_in > 0 && held[fill] != it.data_byte) rows_match = 0;
          fill++;
          if (fill == row_len) begin
            rows_in++;
            if (rows_in == 1) begin
              take_incoming();
              if (rows_in >= geo_rows()) start_group();
            end else if (rows_match && repeats < REPEAT_MAX) begin
              repeats++; fill = 0; rows_match = 1;
              if (rows_in >= geo_rows()) start_group();
            end else start_group();
          end
        end
      end else if (ph == PH_HEAD) begin
        r.out_valid = 1;
        r.out_byte = (head_idx < 2) ? BYTE_ZERO : (head_idx == 2) ? BYTE_ONES : repeats[7:0];
        head_idx++;
        if (head_idx >= 4) build_plane();
      end else if (ph == PH_PLANE) begin
        r.out_valid = 1;
        r.out_byte = code[emit_pos];
        emit_pos++;
        if (emit_pos >= code_len) begin
          cur_plane++;
          if (cur_plane >= geo_p()) begin
            if (finish_group()) r.out_last = 1;
          end else build_plane();
        end
      end
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.accepted !== exp_r.accepted) begin
        $error("accepted: expected %0d actual %0d", exp_r.accepted, got.accepted); errors++;
      end
      if (got.out_valid !== exp_r.out_valid) begin
        $error("out_valid: expected %0d actual %0d", exp_r.out_valid, got.out_valid); errors++;
      end
      if (got.out_byte !== exp_r.out_byte) begin
        $error("out_byte: expected %h actual %h", exp_r.out_byte, got.out_byte); errors++;
      end
      if (got.out_last !== exp_r.out_last) begin
        $error("out_last: expected %0d actual %0d", exp_r.out_last, got.out_last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 0;
  result_t result;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  encoder_scoreboard sb = new();
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  logic [7:0] row_buf[STORE_DEPTH];

  bitplane_scanline_rle_encoder dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // result side: random stalls, checking and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result);
      if ((result_valid && result_ready) || (item_valid && item_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 0;
      end else begin
        result_ready <= 1;
        if (result_valid && ((items_sent / 64) % 3 != 0)) stall_left = $urandom_range(0, 16);
      end
    end
  end

  // send one item, holding valid until it is taken
  task automatic send_item(item_t it);
    int gap;
    gap = ((items_sent / 48) % 3 == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    void'(sb.note_item(it));
    items_sent++;
  endtask

  // write enable stays high across back-to-back writes, the caller drops it
  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic wait_drained();
    item_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // fill one row with zero, ones, pattern, literal and alternating segments
  task automatic make_row(int unsigned n, int rep_pct, bit have_prev);
    int unsigned x, len, style;
    logic [7:0] v;
    if (have_prev && $urandom_range(0, 99) < rep_pct) return;
    x = 0;
    while (x < n) begin
      style = $urandom_range(0, 5);
      len = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, n);
      v = 8'($urandom);
      for (int i = 0; i < len && x < n; i++) begin
        case (style)
          0: row_buf[x] = BYTE_ZERO;
          1: row_buf[x] = BYTE_ONES;
          2: row_buf[x] = v;
          3: row_buf[x] = 8'($urandom);
          4: row_buf[x] = i[0] ? BYTE_ZERO : 8'($urandom);
          default: row_buf[x] = (i % 3 == 2) ? 8'($urandom) : v;
        endcase
        x++;
      end
    end
  endtask

  // configure, push rows and pull the code, with some stray items mixed in
  task automatic run_image(int lbv, int pcv, int lcv, int nrows, int rep_pct, bit hold_off);
    item_t it;
    int unsigned n, pos, rows_done, steps;
    bit noise;
    write_cfg(CFG_LINE_BYTES, CFG_DW'(lbv));
    write_cfg(CFG_PLANE_COUNT, CFG_DW'(pcv));
    write_cfg(CFG_LINE_COUNT, CFG_DW'(lcv));
    cfg_we <= 0;
    n = sb.geo_w() * sb.geo_p();
    pos = 0; rows_done = 0; steps = 0;
    make_row(n, rep_pct, 0);
    forever begin
      if (sb.ph == PH_DONE) break;
      if (sb.ph == PH_IDLE && rows_done >= nrows) break;
      if (hold_off && steps == 40) begin
        item_valid <= 0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      noise = ($urandom_range(0, 99) < 8);
      it.data_byte = 8'($urandom);
      if (sb.ph == PH_IDLE && rows_done < nrows) begin
        it.command = noise ? CMD_PULL : CMD_PUSH;
        if (!noise) it.data_byte = row_buf[pos];
      end else begin
        it.command = noise ? CMD_PUSH : CMD_PULL;
      end
      send_item(it);
      steps++;
      if (sb.expected_q[$].accepted && !noise) begin
        pos++;
        if (pos == n) begin
          pos = 0; rows_done++;
          make_row(n, rep_pct, 1);
        end
      end
    end
    // stray pulls and pushes after the image
    repeat ($urandom_range(1, 4)) begin
      it.command = 1'($urandom); it.data_byte = 8'($urandom);
      send_item(it);
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset geometry, extremes of bytes, pull with nothing ready
    begin
      item_t it;
      it = '{command: CMD_PULL, data_byte: 8'hFF}; send_item(it);
      it = '{command: CMD_PUSH, data_byte: 8'h00}; send_item(it);
      repeat (2) begin it = '{command: CMD_PULL, data_byte: 8'h00}; send_item(it); end
      it = '{command: CMD_PUSH, data_byte: 8'hFF}; send_item(it);
      wait_drained();
    end
    run_image(1, 1, 1, 1, 0, 0);
    run_image(0, 0, 0, 1, 0, 0);
    run_image(511, 1, 2, 2, 30, 0);
    run_image(256, 1, 3, 3, 50, 0);
    run_image(3, 15, 2, 2, 50, 0);
    run_image(2, 8, 4, 4, 60, 0);
    run_image(1, 1, 65535, 300, 100, 0);
    run_image(5, 2, 6, 6, 40, 1);
    while (items_sent < 1600)
      run_image($urandom_range(1, 24), $urandom_range(1, 4), $urandom_range(1, 6), 6, 40, 0);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
